>>> rtl/rdh_pkg.sv
package rdh_pkg;

    localparam int KIND_W    = 2;
    localparam int ROW_W     = 9;
    localparam int DISP_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam int DEF_ROWS = 512;
    localparam int DEF_BINS = 256;

    localparam logic [DISP_W-1:0] DEF_THRESHOLD = 8'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PIXEL = 2'd0,
        KIND_READ  = 2'd1,
        KIND_FRAME = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INC,
        OP_READ
    } t_op;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage

>>> rtl/row_disparity_histogram_top.sv
// Per-row disparity histogram (v-disparity). One transaction is accepted per clock unless the
// input is stalled: the bin memory is read on acceptance and written back when the transaction
// leaves the read stage, with the write forwarded to a read of the same bin issued at the same
// edge. A read transaction stalls the input only while the output register holds an untaken
// result. After reset the block clears all 2**(max(1, clog2(min(ROWS,512))) + clog2(BINS))
// entries of the bin memory (131072 with the default sizes), one entry per cycle; tready stays
// low during the sweep, configuration writes are taken throughout.
module row_disparity_histogram_top #(
    parameter int ROWS = rdh_pkg::DEF_ROWS,
    parameter int BINS = rdh_pkg::DEF_BINS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rdh_pkg::DISP_W-1:0]    i_cfg_wr_data,    // count_threshold
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [rdh_pkg::S_TDATA_W-1:0] i_s_axis_tdata,   // row_index, disparity_value
    input  logic [rdh_pkg::KIND_W-1:0]    i_s_axis_tuser,   // kind
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [rdh_pkg::M_TDATA_W-1:0] o_m_axis_tdata    // bin_count, frame_max
);
    import rdh_pkg::*;

    localparam int ROWS_USED = (ROWS < 512) ? ROWS : 512;
    localparam int ROW_AW    = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;
    localparam int BIN_W     = $clog2(BINS);
    localparam int ADDR_W    = ROW_AW + BIN_W;
    localparam int DEPTH     = 2 ** ADDR_W;

    logic [COUNT_W-1:0] mem [DEPTH];

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic w_clearing;

    logic [DISP_W-1:0] r_threshold;
    logic [DISP_W-1:0] r_max;

    logic [ROW_W-1:0]  w_row;
    logic [DISP_W-1:0] w_disp;
    logic              w_accept;
    logic              w_hit;
    logic [ADDR_W-1:0] w_raddr;
    t_op               w_op;

    logic              r_s1_valid;
    t_op               r_s1_op;
    logic              r_s1_hit;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [COUNT_W-1:0] r_rdata;

    logic              r_fwd_valid;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [COUNT_W-1:0] r_fwd_data;

    logic               w_s1_leave;
    logic               w_advance;
    logic [COUNT_W-1:0] w_old;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [COUNT_W-1:0] w_wdata;

    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic [DISP_W-1:0]  r_out_max;

    // state sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr_addr == '1) n_state = ST_RUN;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_CLEAR: w_clearing = 1'b1;
            default:  w_clearing = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (w_clearing) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= DEF_THRESHOLD;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    // decode
    assign w_row   = i_s_axis_tdata[ROW_W-1:0];
    assign w_disp  = i_s_axis_tdata[ROW_W +: DISP_W];
    assign w_hit   = (32'(w_row) < ROWS) && (32'(w_disp) < BINS);
    assign w_raddr = {w_row[ROW_AW-1:0], w_disp[BIN_W-1:0]};

    always_comb begin
        case (i_s_axis_tuser)
            KIND_PIXEL: w_op = (w_hit && (w_disp > r_threshold)) ? OP_INC : OP_NONE;
            KIND_READ:  w_op = OP_READ;
            default:    w_op = OP_NONE;
        endcase
    end

    assign w_s1_leave = r_s1_valid &&
                        ((r_s1_op != OP_READ) || !r_out_valid || i_m_axis_tready);
    assign w_advance  = !r_s1_valid || w_s1_leave;
    assign o_s_axis_tready = w_advance && !w_clearing;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
        end else if (w_accept) begin
            case (i_s_axis_tuser)
                KIND_PIXEL: if (w_disp > r_max) r_max <= w_disp;
                KIND_FRAME: r_max <= '0;
                default:    r_max <= r_max;
            endcase
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op   <= w_op;
            r_s1_hit  <= w_hit;
            r_s1_addr <= w_raddr;
        end
    end

    // modify and write back
    assign w_old   = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_rdata;
    assign w_we    = w_clearing ||
                     (w_s1_leave && r_s1_hit && ((r_s1_op == OP_INC) || (r_s1_op == OP_READ)));
    assign w_waddr = w_clearing ? r_clr_addr : r_s1_addr;
    assign w_wdata = (!w_clearing && (r_s1_op == OP_INC)) ? w_old + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        if (w_accept) r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (w_advance) begin
            r_fwd_valid <= w_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_fwd_addr <= w_waddr;
            r_fwd_data <= w_wdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_leave && (r_s1_op == OP_READ)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_leave && (r_s1_op == OP_READ)) begin
            r_out_count <= r_s1_hit ? w_old : '0;
            r_out_max   <= r_max;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_max, r_out_count};

endmodule

>>> rtl/rdh_checker.sv
module rdh_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_wr_en,
    input logic [rdh_pkg::DISP_W-1:0]    i_cfg_wr_data,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [rdh_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input logic [rdh_pkg::KIND_W-1:0]    i_s_axis_tuser,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [rdh_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import rdh_pkg::*;

    logic w_acc_read;
    logic w_acc_frame;

    assign w_acc_read  = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == KIND_READ);
    assign w_acc_frame = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == KIND_FRAME);

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready during bin clearing sweep");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_frame_max_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) && $past(w_acc_read, 2) && $past(w_acc_frame, 3)
        |-> o_m_axis_tdata[M_TDATA_W-1:COUNT_W] == '0)
        else $error("frame maximum not cleared by frame transaction");

endmodule

bind row_disparity_histogram_top rdh_checker u_rdh_checker (.*);
